// ===== rtl/sst_pkg.sv =====
`default_nettype none

package sst_pkg;

   // Default depth of the key store.
   localparam int MAX_ENTRIES_DEF = 16;

   // A dump emits at most this many words.
   localparam int DUMP_LIMIT = 16;

   // Field widths of the request and response words.
   localparam int KEY_W  = 32;
   localparam int POS_W  = 4;
   localparam int HELD_W = 5;
   localparam int CAP_W  = 5;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Request codes.
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_DUMP   = 2'd3
   } sst_op_type;

   // Response status codes.
   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_FOUND     = 3'd5,
      ST_DUMP_ITEM = 3'd6,
      ST_EMPTY     = 3'd7
   } sst_status_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DUMP_RD,
      S_DUMP_CHK,
      S_EMIT
   } sst_state_type;

   // One response word as it travels from the controller to the output stage.
   typedef struct packed {
      sst_status_type     status;
      logic [POS_W-1:0]   position;
      logic [KEY_W-1:0]   value;
      logic [HELD_W-1:0]  entries_held;
      logic               last;
   } sst_rsp_type;

   // Builds a response word.
   function automatic sst_rsp_type make_rsp(sst_status_type st, logic [POS_W-1:0] pos,
                                            logic [KEY_W-1:0] val, logic [HELD_W-1:0] held,
                                            logic lst);
      sst_rsp_type r;
      r.status       = st;
      r.position     = pos;
      r.value        = val;
      r.entries_held = held;
      r.last         = lst;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sorted_set_table.sv =====
// Sorted key set held in a synchronous store with one write and one read port, walked by
// one controller. A search, insert or remove scans entries in order, a read and a compare
// per entry, and an insert or remove also shifts entries, a read and a write per entry shifted.
// A dump emits each word before it reads the next entry. One request is in work at a time.
// Reset clears the entry count and sets capacity to 16; the store itself is not cleared.
`default_nettype none

module sorted_set_table #(
   parameter int MAX_ENTRIES = sst_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_type,
   input  wire logic signed [sst_pkg::KEY_W-1:0] req_key,
   // Response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [2:0]                   rsp_status,
   output logic      [sst_pkg::POS_W-1:0]    rsp_position,
   output logic signed [sst_pkg::KEY_W-1:0]  rsp_value,
   output logic      [sst_pkg::HELD_W-1:0]   rsp_entries_held,
   output logic                              rsp_last,
   // Capacity register
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [sst_pkg::CAP_W-1:0]    csr_data
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic                      mem_wr_en;
   logic [IDX_W-1:0]          mem_wr_addr;
   logic [sst_pkg::KEY_W-1:0] mem_wr_data;
   logic                      mem_rd_en;
   logic [IDX_W-1:0]          mem_rd_addr;
   logic [sst_pkg::KEY_W-1:0] mem_rd_data;
   logic                      emit_valid;
   logic                      emit_ready;
   sst_pkg::sst_rsp_type      emit_word;

   // The capacity register takes a word in any cycle.
   assign csr_ready = 1'b1;

   sst_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_key     (req_key),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .emit_valid  (emit_valid),
      .emit_word   (emit_word),
      .emit_ready  (emit_ready)
   );

   sst_mem #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sst_rsp u_rsp (
      .clock            (clock),
      .reset            (reset),
      .emit_valid       (emit_valid),
      .emit_word        (emit_word),
      .emit_ready       (emit_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_value        (rsp_value),
      .rsp_entries_held (rsp_entries_held),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/sst_mem.sv =====
`default_nettype none

module sst_mem #(
   parameter int MAX_ENTRIES = sst_pkg::MAX_ENTRIES_DEF,
   parameter int IDX_W       = $clog2(MAX_ENTRIES)
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [IDX_W-1:0]         wr_addr,
   input  wire logic [sst_pkg::KEY_W-1:0] wr_data,
   input  wire logic                     rd_en,
   input  wire logic [IDX_W-1:0]         rd_addr,
   output logic      [sst_pkg::KEY_W-1:0] rd_data
);

   logic [sst_pkg::KEY_W-1:0] mem_ff [MAX_ENTRIES];
   logic [sst_pkg::KEY_W-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sst_rsp.sv =====
`default_nettype none

module sst_rsp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        emit_valid,
   input  wire sst_pkg::sst_rsp_type        emit_word,
   output logic                             emit_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [2:0]                  rsp_status,
   output logic      [sst_pkg::POS_W-1:0]   rsp_position,
   output logic signed [sst_pkg::KEY_W-1:0] rsp_value,
   output logic      [sst_pkg::HELD_W-1:0]  rsp_entries_held,
   output logic                             rsp_last
);

   logic                 valid_ff;
   logic                 valid_in;
   sst_pkg::sst_rsp_type word_ff;

   // The register takes a new word when empty or when its word leaves now.
   assign emit_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (emit_ready) begin
         valid_in = emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (emit_ready && emit_valid) begin
         word_ff <= emit_word;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = word_ff.status;
   assign rsp_position     = word_ff.position;
   assign rsp_value        = $signed(word_ff.value);
   assign rsp_entries_held = word_ff.entries_held;
   assign rsp_last         = word_ff.last;

endmodule

`default_nettype wire

// ===== rtl/sst_ctrl.sv =====
`default_nettype none

module sst_ctrl #(
   parameter int MAX_ENTRIES = sst_pkg::MAX_ENTRIES_DEF,
   parameter int IDX_W       = $clog2(MAX_ENTRIES),
   parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // Request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_type,
   input  wire logic [sst_pkg::KEY_W-1:0]   req_key,
   // Capacity register
   input  wire logic                        csr_valid,
   input  wire logic [sst_pkg::CAP_W-1:0]   csr_data,
   // Key store
   output logic                             mem_wr_en,
   output logic      [IDX_W-1:0]            mem_wr_addr,
   output logic      [sst_pkg::KEY_W-1:0]   mem_wr_data,
   output logic                             mem_rd_en,
   output logic      [IDX_W-1:0]            mem_rd_addr,
   input  wire logic [sst_pkg::KEY_W-1:0]   mem_rd_data,
   // Response words
   output logic                             emit_valid,
   output sst_pkg::sst_rsp_type             emit_word,
   input  wire logic                        emit_ready
);

   // Wide enough for the count, the capacity and the dump limit.
   localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

   sst_pkg::sst_state_type state_ff, state_in;
   sst_pkg::sst_op_type    op_ff, op_in;
   logic [sst_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [CNT_W-1:0]           ptr_ff, ptr_in;
   logic [sst_pkg::CAP_W-1:0]  capacity_ff;
   sst_pkg::sst_rsp_type       res_ff, res_in;

   logic [CNT_W-1:0] ptr_inc;
   logic [CNT_W-1:0] ptr_dec;
   logic [CNT_W-1:0] count_inc;
   logic [CNT_W-1:0] count_dec;
   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] max_ext;
   logic [CMP_W-1:0] cap_eff;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] dump_n;
   logic             is_full;
   logic             dump_last;
   sst_pkg::sst_rsp_type dump_word;

   // Capacity register; always writable.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= sst_pkg::CAP_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_data;
      end
   end

   // Pointer arithmetic and limits.
   assign ptr_inc   = ptr_ff + CNT_W'(1);
   assign ptr_dec   = ptr_ff - CNT_W'(1);
   assign count_inc = count_ff + CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);
   assign cap_ext   = CMP_W'(capacity_ff);
   assign max_ext   = CMP_W'(MAX_ENTRIES);
   assign cap_eff   = (cap_ext > max_ext) ? max_ext : cap_ext;
   assign count_ext = CMP_W'(count_ff);
   assign is_full   = count_ext >= cap_eff;
   assign dump_n    = (count_ext > CMP_W'(sst_pkg::DUMP_LIMIT)) ?
                      CMP_W'(sst_pkg::DUMP_LIMIT) : count_ext;
   assign dump_last = (CMP_W'(ptr_ff) + CMP_W'(1)) == dump_n;
   assign dump_word = sst_pkg::make_rsp(sst_pkg::ST_DUMP_ITEM, sst_pkg::POS_W'(ptr_ff),
                                        mem_rd_data, sst_pkg::HELD_W'(count_ff), dump_last);

   assign req_stall = (state_ff != sst_pkg::S_IDLE);

   // Next state and outputs.
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      ptr_in      = ptr_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = ptr_ff[IDX_W-1:0];
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff[IDX_W-1:0];
      emit_valid  = 1'b0;
      emit_word   = res_ff;

      unique case (state_ff)
         sst_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in  = sst_pkg::sst_op_type'(req_type);
               key_in = req_key;
               ptr_in = '0;
               unique case (sst_pkg::sst_op_type'(req_type))
                  sst_pkg::OP_INSERT: begin
                     if (is_full) begin
                        res_in   = sst_pkg::make_rsp(sst_pkg::ST_FULL, '0, req_key,
                                                     sst_pkg::HELD_W'(count_ff), 1'b1);
                        state_in = sst_pkg::S_EMIT;
                     end else begin
                        state_in = sst_pkg::S_SCAN_RD;
                     end
                  end
                  sst_pkg::OP_REMOVE, sst_pkg::OP_SEARCH: begin
                     state_in = sst_pkg::S_SCAN_RD;
                  end
                  sst_pkg::OP_DUMP: begin
                     if (count_ff == '0) begin
                        res_in   = sst_pkg::make_rsp(sst_pkg::ST_EMPTY, '0, '0,
                                                     sst_pkg::HELD_W'(count_ff), 1'b1);
                        state_in = sst_pkg::S_EMIT;
                     end else begin
                        state_in = sst_pkg::S_DUMP_RD;
                     end
                  end
                  default: state_in = sst_pkg::S_IDLE;
               endcase
            end
         end

         // Read the next entry of the ordered scan, or finish at the end.
         sst_pkg::S_SCAN_RD: begin
            if (ptr_ff == count_ff) begin
               if (op_ff == sst_pkg::OP_INSERT) begin
                  idx_in   = count_ff;
                  state_in = sst_pkg::S_SHIFT_RD;
               end else begin
                  res_in   = sst_pkg::make_rsp(sst_pkg::ST_NOT_FOUND, '0, key_ff,
                                               sst_pkg::HELD_W'(count_ff), 1'b1);
                  state_in = sst_pkg::S_EMIT;
               end
            end else begin
               mem_rd_en = 1'b1;
               state_in  = sst_pkg::S_SCAN_CHK;
            end
         end

         // Compare the entry with the key; the list is ascending, so the
         // first entry not below the key ends the scan.
         sst_pkg::S_SCAN_CHK: begin
            if (mem_rd_data == key_ff) begin
               state_in = sst_pkg::S_EMIT;
               unique case (op_ff)
                  sst_pkg::OP_INSERT: begin
                     res_in = sst_pkg::make_rsp(sst_pkg::ST_DUPLICATE,
                                                sst_pkg::POS_W'(ptr_ff), key_ff,
                                                sst_pkg::HELD_W'(count_ff), 1'b1);
                  end
                  sst_pkg::OP_SEARCH: begin
                     res_in = sst_pkg::make_rsp(sst_pkg::ST_FOUND,
                                                sst_pkg::POS_W'(ptr_ff), key_ff,
                                                sst_pkg::HELD_W'(count_ff), 1'b1);
                  end
                  default: begin
                     idx_in   = ptr_ff;
                     state_in = sst_pkg::S_SHIFT_RD;
                  end
               endcase
            end else if ($signed(mem_rd_data) > $signed(key_ff)) begin
               if (op_ff == sst_pkg::OP_INSERT) begin
                  idx_in   = ptr_ff;
                  ptr_in   = count_ff;
                  state_in = sst_pkg::S_SHIFT_RD;
               end else begin
                  res_in   = sst_pkg::make_rsp(sst_pkg::ST_NOT_FOUND, '0, key_ff,
                                               sst_pkg::HELD_W'(count_ff), 1'b1);
                  state_in = sst_pkg::S_EMIT;
               end
            end else begin
               ptr_in   = ptr_inc;
               state_in = sst_pkg::S_SCAN_RD;
            end
         end

         // Shift one entry: up for an insert, down for a remove.
         sst_pkg::S_SHIFT_RD: begin
            if (op_ff == sst_pkg::OP_INSERT) begin
               if (ptr_ff == idx_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = idx_ff[IDX_W-1:0];
                  mem_wr_data = key_ff;
                  count_in    = count_inc;
                  res_in      = sst_pkg::make_rsp(sst_pkg::ST_INSERTED,
                                                  sst_pkg::POS_W'(idx_ff), key_ff,
                                                  sst_pkg::HELD_W'(count_inc), 1'b1);
                  state_in    = sst_pkg::S_EMIT;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ptr_dec[IDX_W-1:0];
                  state_in    = sst_pkg::S_SHIFT_WR;
               end
            end else begin
               if (ptr_inc == count_ff) begin
                  count_in = count_dec;
                  res_in   = sst_pkg::make_rsp(sst_pkg::ST_REMOVED,
                                               sst_pkg::POS_W'(idx_ff), key_ff,
                                               sst_pkg::HELD_W'(count_dec), 1'b1);
                  state_in = sst_pkg::S_EMIT;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ptr_inc[IDX_W-1:0];
                  state_in    = sst_pkg::S_SHIFT_WR;
               end
            end
         end

         sst_pkg::S_SHIFT_WR: begin
            mem_wr_en = 1'b1;
            ptr_in    = (op_ff == sst_pkg::OP_INSERT) ? ptr_dec : ptr_inc;
            state_in  = sst_pkg::S_SHIFT_RD;
         end

         sst_pkg::S_DUMP_RD: begin
            mem_rd_en = 1'b1;
            state_in  = sst_pkg::S_DUMP_CHK;
         end

         // Emit one dump word; the read data holds while the output waits.
         sst_pkg::S_DUMP_CHK: begin
            emit_valid = 1'b1;
            emit_word  = dump_word;
            if (emit_ready) begin
               ptr_in   = ptr_inc;
               state_in = dump_last ? sst_pkg::S_IDLE : sst_pkg::S_DUMP_RD;
            end
         end

         sst_pkg::S_EMIT: begin
            emit_valid = 1'b1;
            if (emit_ready) begin
               state_in = sst_pkg::S_IDLE;
            end
         end

         default: state_in = sst_pkg::S_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sst_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
      ptr_ff <= ptr_in;
      res_ff <= res_in;
   end

   // The list never grows past the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count exceeds store depth");

   // A pending response reports the count as it stands.
   a_held_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sst_pkg::S_EMIT) |-> (res_ff.entries_held == sst_pkg::HELD_W'(count_ff)))
      else $error("pending response disagrees with entry count");

   // Stores stay within the held list plus the one free slot of an insert.
   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && state_ff == sst_pkg::S_SHIFT_WR) |-> (ptr_ff <= count_ff))
      else $error("shift writes past the end of the list");

   // A dump only reads held entries.
   a_dump_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sst_pkg::S_DUMP_CHK) |-> (ptr_ff < count_ff))
      else $error("dump reads past the end of the list");

endmodule

`default_nettype wire

// ===== bench/sorted_set_table_checker.sv =====
`default_nettype none

module sorted_set_table_checker
   import sst_pkg::*;
#(
   parameter int DEPTH = MAX_ENTRIES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_stall,
   input  wire logic [1:0]                req_type,
   input  wire logic signed [KEY_W-1:0]   req_key,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire logic [2:0]                rsp_status,
   input  wire logic [POS_W-1:0]          rsp_position,
   input  wire logic signed [KEY_W-1:0]   rsp_value,
   input  wire logic [HELD_W-1:0]         rsp_entries_held,
   input  wire logic                      rsp_last,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [CAP_W-1:0]          csr_data,
   output int                             fail_count,
   output int                             words_owed
);

   // Shadow copy of the table and of the capacity register.
   logic signed [KEY_W-1:0] table_keys [DEPTH];
   int                      held_count;
   logic [CAP_W-1:0]        capacity_reg;
   int                      mismatches;

   // Response words still owed by the block, oldest first.
   sst_rsp_type awaited_words [$];

   initial begin
      held_count   = 0;
      capacity_reg = CAP_RESET;
      mismatches   = 0;
      fail_count   = 0;
      words_owed   = 0;
   end

   // Queues one expected word; the held count is taken after the request.
   function automatic void owe_word(sst_status_type st, int pos, logic [KEY_W-1:0] val,
                                    logic lst);
      sst_rsp_type w;
      w.status       = st;
      w.position     = pos[POS_W-1:0];
      w.value        = val;
      w.entries_held = held_count[HELD_W-1:0];
      w.last         = lst;
      awaited_words.push_back(w);
   endfunction

   // Index of the key, or the held count when the key is absent.
   function automatic int locate_key(logic signed [KEY_W-1:0] k);
      for (int i = 0; i < held_count; i++) begin
         if (table_keys[i] == k) return i;
      end
      return held_count;
   endfunction

   // Applies one request to the shadow table and queues the words it causes.
   function automatic void update_table(sst_op_type op, logic signed [KEY_W-1:0] k);
      int eff_cap;
      int idx;
      int n;
      eff_cap = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
      case (op)
         OP_INSERT: begin
            // A full table refuses the key even when it is already present.
            if (held_count >= eff_cap) begin
               owe_word(ST_FULL, 0, k, 1'b1);
            end else begin
               idx = locate_key(k);
               if (idx < held_count) begin
                  owe_word(ST_DUPLICATE, idx, k, 1'b1);
               end else begin
                  idx = 0;
                  while (idx < held_count && table_keys[idx] < k) idx++;
                  for (int i = held_count; i > idx; i--) table_keys[i] = table_keys[i-1];
                  table_keys[idx] = k;
                  held_count++;
                  owe_word(ST_INSERTED, idx, k, 1'b1);
               end
            end
         end
         OP_REMOVE, OP_SEARCH: begin
            idx = locate_key(k);
            if (idx >= held_count) begin
               owe_word(ST_NOT_FOUND, 0, k, 1'b1);
            end else if (op == OP_SEARCH) begin
               owe_word(ST_FOUND, idx, k, 1'b1);
            end else begin
               for (int i = idx; i + 1 < held_count; i++) table_keys[i] = table_keys[i+1];
               held_count--;
               owe_word(ST_REMOVED, idx, k, 1'b1);
            end
         end
         default: begin
            // A dump of an empty table gives a single empty status word.
            if (held_count == 0) begin
               owe_word(ST_EMPTY, 0, '0, 1'b1);
            end else begin
               n = (held_count > DUMP_LIMIT) ? DUMP_LIMIT : held_count;
               for (int i = 0; i < n; i++) begin
                  owe_word(ST_DUMP_ITEM, i, table_keys[i], (i + 1 == n));
               end
            end
         end
      endcase
   endfunction

   // Watch all three channels at each edge and compare the response word.
   always @(posedge clock) begin
      sst_rsp_type w;
      if (reset) begin
         held_count   = 0;
         capacity_reg = CAP_RESET;
         awaited_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_reg = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_words.size() == 0) begin
               $error("unexpected response word: status %0d, value %0d",
                      rsp_status, rsp_value);
               mismatches++;
            end else begin
               w = awaited_words.pop_front();
               if (rsp_status !== w.status) begin
                  $error("status: expected %0d, actual %0d", w.status, rsp_status);
                  mismatches++;
               end
               if (rsp_position !== w.position) begin
                  $error("position: expected %0d, actual %0d", w.position, rsp_position);
                  mismatches++;
               end
               if (rsp_value !== w.value) begin
                  $error("value: expected %0d, actual %0d", $signed(w.value), rsp_value);
                  mismatches++;
               end
               if (rsp_entries_held !== w.entries_held) begin
                  $error("entries_held: expected %0d, actual %0d", w.entries_held,
                         rsp_entries_held);
                  mismatches++;
               end
               if (rsp_last !== w.last) begin
                  $error("last: expected %0d, actual %0d", w.last, rsp_last);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            update_table(sst_op_type'(req_type), req_key);
         end
      end
      fail_count <= mismatches;
      words_owed <= awaited_words.size();
   end

endmodule

`default_nettype wire

// ===== bench/sorted_set_table_tb.sv =====
`default_nettype none

module sorted_set_table_tb;
   import sst_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 100;
   localparam int WORDS_PER_PHASE = 65;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_type = OP_INSERT;
   logic signed [KEY_W-1:0]   req_key = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [2:0]                rsp_status;
   logic [POS_W-1:0]          rsp_position;
   logic signed [KEY_W-1:0]   rsp_value;
   logic [HELD_W-1:0]         rsp_entries_held;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CAP_W-1:0]          csr_data = '0;

   int fail_count;
   int words_owed;
   int send_idle_pct = 9;
   int recv_idle_pct = 76;
   int cycle_count = 0;

   sorted_set_table uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_position(rsp_position),
      .rsp_value(rsp_value),
      .rsp_entries_held(rsp_entries_held),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   sorted_set_table_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_position(rsp_position),
      .rsp_value(rsp_value),
      .rsp_entries_held(rsp_entries_held),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .words_owed(words_owed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offers one request word, with random idle cycles ahead of it, and waits until taken.
   task automatic send_word(input sst_op_type op, input logic signed [KEY_W-1:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= op;
      req_key   <= k;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Lets every owed word arrive and the block go quiet, then writes the capacity.
   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random requests; most keys come from a narrow range so hits and full tables are common.
   task automatic random_words(input int count);
      sst_op_type              op;
      logic signed [KEY_W-1:0] k;
      int                      pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40) op = OP_INSERT;
         else if (pick < 62) op = OP_REMOVE;
         else if (pick < 85) op = OP_SEARCH;
         else op = OP_DUMP;
         case ($urandom_range(9))
            0: k = $urandom;
            1: k = $urandom_range(1) ? KEY_MAX : KEY_MIN;
            default: k = $signed($urandom_range(24)) - 12;
         endcase
         send_word(op, k);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Capacity above the table depth saturates at the depth.
      set_capacity(5'd31);

      // Empty table, extreme keys, signed ordering, duplicates and every operation.
      send_word(OP_DUMP, 32'sd77);
      send_word(OP_REMOVE, 32'sd5);
      send_word(OP_SEARCH, 32'sd0);
      send_word(OP_INSERT, 32'sd0);
      send_word(OP_INSERT, KEY_MAX);
      send_word(OP_INSERT, KEY_MIN);
      send_word(OP_INSERT, -32'sd1);
      send_word(OP_INSERT, 32'sd1);
      send_word(OP_INSERT, 32'sd0);
      send_word(OP_SEARCH, -32'sd1);
      send_word(OP_SEARCH, 32'sd2);
      send_word(OP_DUMP, -32'sd1);
      send_word(OP_REMOVE, KEY_MIN);
      send_word(OP_REMOVE, KEY_MAX);
      send_word(OP_REMOVE, 32'sd1);
      send_word(OP_REMOVE, 32'sd1);
      send_word(OP_DUMP, 32'sd0);

      // Zero capacity refuses even a key that is already held.
      set_capacity(5'd0);
      send_word(OP_INSERT, 32'sd0);

      // Capacity below the held count: inserts stay refused until enough removes.
      set_capacity(5'd1);
      send_word(OP_INSERT, 32'sd3);
      send_word(OP_REMOVE, -32'sd1);
      send_word(OP_INSERT, 32'sd3);
      send_word(OP_REMOVE, 32'sd0);
      send_word(OP_INSERT, 32'sd3);
      send_word(OP_INSERT, 32'sd4);

      // Sender mostly busy, receiver mostly stalled.
      set_capacity(5'd16);
      random_words(WORDS_PER_PHASE);
      set_capacity(5'd5);
      random_words(WORDS_PER_PHASE);

      // Sender mostly idle, receiver mostly ready.
      send_idle_pct = 76;
      recv_idle_pct = 9;
      set_capacity(5'd31);
      random_words(WORDS_PER_PHASE);
      set_capacity(5'd1);
      random_words(WORDS_PER_PHASE);

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_capacity(5'd12);
      random_words(WORDS_PER_PHASE);
      set_capacity(5'd16);
      random_words(WORDS_PER_PHASE);

      // Drain what is still owed, then let the block settle.
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && words_owed == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sorted_set_table.f =====
rtl/sst_pkg.sv
rtl/sst_mem.sv
rtl/sst_rsp.sv
rtl/sst_ctrl.sv
rtl/sorted_set_table.sv
bench/sorted_set_table_checker.sv
bench/sorted_set_table_tb.sv
